### src/fmce_pkg.sv
// Package for the framed message CRC-16 encoder: work item type, step codes,
// configuration type and the CRC-16/MODBUS byte update function.
// No dependencies.
`default_nettype none

package fmce_pkg;

    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_BODY  = 1'b1;

    localparam int STEP_W = 4;

    localparam logic [STEP_W-1:0] HDR_HEAD    = 4'd0;
    localparam logic [STEP_W-1:0] HDR_TAIL    = 4'd1;
    localparam logic [STEP_W-1:0] HDR_SENDER  = 4'd2;
    localparam logic [STEP_W-1:0] HDR_RECV    = 4'd3;
    localparam logic [STEP_W-1:0] HDR_CODE    = 4'd4;
    localparam logic [STEP_W-1:0] HDR_SUB     = 4'd5;
    localparam logic [STEP_W-1:0] HDR_LEN_LO  = 4'd6;
    localparam logic [STEP_W-1:0] HDR_LEN_HI  = 4'd7;
    localparam logic [STEP_W-1:0] HDR_SEQ_LO  = 4'd8;
    localparam logic [STEP_W-1:0] HDR_SEQ_HI  = 4'd9;
    localparam logic [STEP_W-1:0] HDR_CRC_LO  = 4'd10;
    localparam logic [STEP_W-1:0] HDR_CRC_HI  = 4'd11;

    localparam logic [STEP_W-1:0] BODY_DATA   = 4'd0;
    localparam logic [STEP_W-1:0] BODY_CRC_LO = 4'd1;
    localparam logic [STEP_W-1:0] BODY_CRC_HI = 4'd2;

    localparam logic REG_HEAD = 1'b0;
    localparam logic REG_TAIL = 1'b1;

    typedef struct packed {
        logic        kind;
        logic        close;
        logic [7:0]  sender;
        logic [7:0]  receiver;
        logic [7:0]  cmd_code;
        logic [7:0]  cmd_sub;
        logic [15:0] body_length;
        logic [15:0] sequence_req;
        logic [7:0]  data_byte;
    } op_t;

    typedef struct packed {
        logic [7:0] head_byte;
        logic [7:0] tail_byte;
    } cfg_t;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### src/fmce_in_if.sv
// Input channel of the framed message CRC-16 encoder: valid, ready and the
// message fields. No dependencies.
`default_nettype none

interface fmce_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [7:0]  sender;
    logic [7:0]  receiver;
    logic [7:0]  cmd_code;
    logic [7:0]  cmd_sub;
    logic [15:0] body_length;
    logic [15:0] sequence_req;
    logic [7:0]  data_byte;

    modport source (output valid, command, sender, receiver, cmd_code, cmd_sub,
                    body_length, sequence_req, data_byte, input ready);
    modport sink (input valid, command, sender, receiver, cmd_code, cmd_sub,
                  body_length, sequence_req, data_byte, output ready);
endinterface

`default_nettype wire

### src/fmce_out_if.sv
// Output channel of the framed message CRC-16 encoder: valid, ready and one
// frame byte with its last flag. No dependencies.
`default_nettype none

interface fmce_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_last;

    modport source (output valid, frame_byte, frame_last, input ready);
    modport sink (input valid, frame_byte, frame_last, output ready);
endinterface

`default_nettype wire

### src/framed_message_crc16_encoder.sv
// Framed message CRC-16 encoder: usage notes below.
// Top level; instantiates fmce_front, fmce_queue and fmce_back.
// Uses fmce_pkg, fmce_in_if, fmce_out_if.
//
// Words arrive on msg (valid/ready). A start word (command 0) produces ten
// header bytes: head, tail, sender, receiver, command code, subcommand,
// body length low/high, sequence low/high. Each body word (command 1) of an
// open frame produces its data byte; after the declared number of body
// bytes, the CRC-16/MODBUS of header and body follows, low byte first, with
// frame_last set on the high byte. A body word with no open frame is
// dropped; a start word abandons any open frame.
// The bytes leave on frame (valid/ready) from an output register.
// The first byte of a word passes through the queue and then the output
// register before it is presented on frame. The output side sends one byte
// per cycle while frame is not stalled: a body word gives one byte, three for
// the last body word; a start word gives ten bytes, twelve with an empty body.
// A queue of QUEUE_DEPTH words lets the input side keep accepting while the
// output side is busy or stalled; msg ready falls only when that queue is full.
// Reset empties the queue and output register, closes any frame, sets the
// CRC to 0xFFFF and the head and tail registers to zero. cfg_we writes
// register cfg_index (0 head, 1 tail) from cfg_data.
`default_nettype none

module framed_message_crc16_encoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    fmce_in_if.sink         msg,
    fmce_out_if.source      frame,
    input  wire logic       cfg_we,
    input  wire logic       cfg_index,
    input  wire logic [7:0] cfg_data
);

    fmce_pkg::cfg_t cfg_reg;
    fmce_pkg::op_t  push_op;
    fmce_pkg::op_t  head_op;
    logic           push;
    logic           pop;
    logic           full;
    logic           head_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                fmce_pkg::REG_HEAD: cfg_reg.head_byte <= cfg_data;
                fmce_pkg::REG_TAIL: cfg_reg.tail_byte <= cfg_data;
                default:            cfg_reg <= cfg_reg;
            endcase
        end
    end

    fmce_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .msg     (msg),
        .full    (full),
        .push_op (push_op),
        .push    (push)
    );

    fmce_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_op    (push_op),
        .pop        (pop),
        .full       (full),
        .head_valid (head_valid),
        .head_op    (head_op)
    );

    fmce_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head_op    (head_op),
        .pop        (pop),
        .frame      (frame)
    );

endmodule

`default_nettype wire

### src/fmce_front.sv
// Front end of the encoder: accepts input words, tracks the open frame and
// its remaining body count, and queues work items. Uses fmce_pkg, fmce_in_if.
`default_nettype none

module fmce_front (
    input  wire logic         clk,
    input  wire logic         rst_n,
    fmce_in_if.sink           msg,
    input  wire logic         full,
    output fmce_pkg::op_t     push_op,
    output logic              push
);

    logic        frame_open_reg;
    logic        frame_open_next;
    logic [15:0] bytes_left_reg;
    logic [15:0] bytes_left_next;
    logic        accept;

    assign msg.ready = !full;
    assign accept    = msg.valid && !full;

    always_comb
    begin
        frame_open_next      = frame_open_reg;
        bytes_left_next      = bytes_left_reg;
        push                 = 1'b0;
        push_op.kind         = msg.command;
        push_op.close        = 1'b0;
        push_op.sender       = msg.sender;
        push_op.receiver     = msg.receiver;
        push_op.cmd_code     = msg.cmd_code;
        push_op.cmd_sub      = msg.cmd_sub;
        push_op.body_length  = msg.body_length;
        push_op.sequence_req = msg.sequence_req;
        push_op.data_byte    = msg.data_byte;
        if (accept)
        begin
            if (msg.command == fmce_pkg::KIND_START)
            begin
                push            = 1'b1;
                push_op.close   = (msg.body_length == 16'd0);
                frame_open_next = (msg.body_length != 16'd0);
                bytes_left_next = msg.body_length;
            end
            else if (frame_open_reg)
            begin
                push            = 1'b1;
                push_op.close   = (bytes_left_reg == 16'd1);
                frame_open_next = (bytes_left_reg != 16'd1);
                bytes_left_next = bytes_left_reg - 16'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_open_reg <= 1'b0;
            bytes_left_reg <= 16'd0;
        end
        else
        begin
            frame_open_reg <= frame_open_next;
            bytes_left_reg <= bytes_left_next;
        end
    end

`ifndef ASSERT_OFF
    a_open_has_count: assert property (@(posedge clk) disable iff (!rst_n)
        frame_open_reg |-> bytes_left_reg != 16'd0)
        else $error("open frame with no body bytes left");

    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("work item queued while queue full");

    a_start_opens: assert property (@(posedge clk) disable iff (!rst_n)
        msg.valid && msg.ready && msg.command == fmce_pkg::KIND_START
        && msg.body_length != 16'd0
        |=> frame_open_reg && bytes_left_reg == $past(msg.body_length))
        else $error("start word did not open a frame");
`endif

endmodule

`default_nettype wire

### src/fmce_queue.sv
// Short register queue of work items between the front and back ends.
// Uses fmce_pkg.
`default_nettype none

module fmce_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire fmce_pkg::op_t push_op,
    input  wire logic          pop,
    output logic               full,
    output logic               head_valid,
    output fmce_pkg::op_t      head_op
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    fmce_pkg::op_t    mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_op    = mem[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

### src/fmce_back.sv
// Back end of the encoder: steps through the queued work items one frame
// byte per cycle while the output is not stalled, keeps the running CRC and
// drives the output register. Uses fmce_pkg, fmce_out_if.
`default_nettype none

module fmce_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire fmce_pkg::cfg_t cfg,
    input  wire logic           head_valid,
    input  wire fmce_pkg::op_t  head_op,
    output logic                pop,
    fmce_out_if.source          frame
);

    logic [fmce_pkg::STEP_W-1:0] step_reg;
    logic [fmce_pkg::STEP_W-1:0] step_next;
    logic [15:0]                 crc_reg;
    logic [15:0]                 crc_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [7:0]                  out_byte_reg;
    logic [7:0]                  out_byte_next;
    logic                        out_last_reg;
    logic                        out_last_next;
    logic                        emit;
    logic                        done;
    logic                        is_crc;
    logic                        is_last;
    logic [7:0]                  sel_byte;
    logic [15:0]                 crc_base;

    assign emit = head_valid && (!out_valid_reg || frame.ready);
    assign pop  = emit && done;

    always_comb
    begin
        sel_byte = 8'h00;
        is_crc   = 1'b0;
        is_last  = 1'b0;
        done     = 1'b0;
        if (head_op.kind == fmce_pkg::KIND_START)
        begin
            case (step_reg)
                fmce_pkg::HDR_HEAD:   sel_byte = cfg.head_byte;
                fmce_pkg::HDR_TAIL:   sel_byte = cfg.tail_byte;
                fmce_pkg::HDR_SENDER: sel_byte = head_op.sender;
                fmce_pkg::HDR_RECV:   sel_byte = head_op.receiver;
                fmce_pkg::HDR_CODE:   sel_byte = head_op.cmd_code;
                fmce_pkg::HDR_SUB:    sel_byte = head_op.cmd_sub;
                fmce_pkg::HDR_LEN_LO: sel_byte = head_op.body_length[7:0];
                fmce_pkg::HDR_LEN_HI: sel_byte = head_op.body_length[15:8];
                fmce_pkg::HDR_SEQ_LO: sel_byte = head_op.sequence_req[7:0];
                fmce_pkg::HDR_SEQ_HI:
                begin
                    sel_byte = head_op.sequence_req[15:8];
                    done     = !head_op.close;
                end
                fmce_pkg::HDR_CRC_LO:
                begin
                    sel_byte = crc_reg[7:0];
                    is_crc   = 1'b1;
                end
                fmce_pkg::HDR_CRC_HI:
                begin
                    sel_byte = crc_reg[15:8];
                    is_crc   = 1'b1;
                    is_last  = 1'b1;
                    done     = 1'b1;
                end
                default:
                begin
                    sel_byte = 8'h00;
                    done     = 1'b1;
                end
            endcase
        end
        else
        begin
            case (step_reg)
                fmce_pkg::BODY_DATA:
                begin
                    sel_byte = head_op.data_byte;
                    done     = !head_op.close;
                end
                fmce_pkg::BODY_CRC_LO:
                begin
                    sel_byte = crc_reg[7:0];
                    is_crc   = 1'b1;
                end
                fmce_pkg::BODY_CRC_HI:
                begin
                    sel_byte = crc_reg[15:8];
                    is_crc   = 1'b1;
                    is_last  = 1'b1;
                    done     = 1'b1;
                end
                default:
                begin
                    sel_byte = 8'h00;
                    done     = 1'b1;
                end
            endcase
        end
    end

    always_comb
    begin
        crc_base = (head_op.kind == fmce_pkg::KIND_START && step_reg == fmce_pkg::HDR_HEAD)
                   ? fmce_pkg::CRC_INIT : crc_reg;
        crc_next       = crc_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && !frame.ready;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        if (emit)
        begin
            if (!is_crc)
            begin
                crc_next = fmce_pkg::crc_feed(crc_base, sel_byte);
            end
            step_next      = done ? '0 : step_reg + 1'b1;
            out_valid_next = 1'b1;
            out_byte_next  = sel_byte;
            out_last_next  = is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            crc_reg       <= fmce_pkg::CRC_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            crc_reg       <= crc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign frame.valid      = out_valid_reg;
    assign frame.frame_byte = out_byte_reg;
    assign frame.frame_last = out_last_reg;

`ifndef ASSERT_OFF
    a_step_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg != '0 |-> head_valid)
        else $error("item left the queue part way through");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> (head_op.kind == fmce_pkg::KIND_START && step_reg <= fmce_pkg::HDR_CRC_HI)
        || (head_op.kind == fmce_pkg::KIND_BODY && step_reg <= fmce_pkg::BODY_CRC_HI))
        else $error("step counter beyond the item's bytes");

    a_pop_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> step_reg == '0)
        else $error("step counter not cleared after item");
`endif

endmodule

`default_nettype wire

### tb/sv/framed_message_crc16_encoder_test.sv
// Self-checking testbench for the framed message CRC-16 encoder: a table of directed
// words, then random frames under several handshake idling phases, all checked byte by
// byte against a built-in frame predictor. Depends on fmce_pkg, fmce_in_if, fmce_out_if.
`default_nettype none

module framed_message_crc16_encoder_test;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 32;
    localparam int SHOWN_MISMATCHES = 10;
    localparam int WORDS_PER_PHASE = 34;

    localparam logic        KIND_START = fmce_pkg::KIND_START;
    localparam logic        KIND_BODY  = fmce_pkg::KIND_BODY;
    localparam logic        REG_HEAD   = fmce_pkg::REG_HEAD;
    localparam logic        REG_TAIL   = fmce_pkg::REG_TAIL;
    localparam logic [15:0] CRC_POLY   = fmce_pkg::CRC_POLY;
    localparam logic [15:0] CRC_INIT   = fmce_pkg::CRC_INIT;

    typedef struct {
        logic        command;
        logic [7:0]  sender;
        logic [7:0]  receiver;
        logic [7:0]  cmd_code;
        logic [7:0]  cmd_sub;
        logic [15:0] body_length;
        logic [15:0] sequence_req;
        logic [7:0]  data_byte;
    } msg_word_t;

    typedef struct {
        logic [7:0] value;
        logic       last;
    } frame_out_t;

    typedef struct {
        msg_word_t word;
        int        n_bytes;
    } directed_row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic       cfg_index = REG_HEAD;
    logic [7:0] cfg_data = 8'h00;

    fmce_in_if  msg_ch ();
    fmce_out_if frame_ch ();

    framed_message_crc16_encoder uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg       (msg_ch),
        .frame     (frame_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    logic [7:0]    head_marker;
    logic [7:0]    tail_marker;
    logic [15:0]   frame_crc;
    logic [15:0]   body_left;
    bit            frame_busy;
    int            bytes_pushed;
    frame_out_t    frame_bytes_due[$];
    directed_row_t directed_rows[$];
    int            mismatches;
    int            gap_pct;
    int            stall_pct;
    int            idle_cycles;

    function automatic logic [15:0] modbus_crc_byte(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        c = crc;
        for (int i = 0; i < 8; i++)
        begin
            if (c[0] ^ b[i])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    function automatic void push_frame_byte(logic [7:0] b, logic last);
        frame_out_t e;
        e.value = b;
        e.last = last;
        frame_bytes_due.push_back(e);
        bytes_pushed++;
    endfunction

    function automatic void push_covered_byte(logic [7:0] b);
        frame_crc = modbus_crc_byte(frame_crc, b);
        push_frame_byte(b, 1'b0);
    endfunction

    function automatic void push_crc_bytes();
        push_frame_byte(frame_crc[7:0], 1'b0);
        push_frame_byte(frame_crc[15:8], 1'b1);
        frame_busy = 1'b0;
        body_left = 16'd0;
    endfunction

    // Returns the number of frame bytes that the word gives rise to.
    function automatic int predict_frame_bytes(msg_word_t w);
        int first;
        first = bytes_pushed;
        if (w.command == KIND_START)
        begin
            frame_crc = CRC_INIT;
            push_covered_byte(head_marker);
            push_covered_byte(tail_marker);
            push_covered_byte(w.sender);
            push_covered_byte(w.receiver);
            push_covered_byte(w.cmd_code);
            push_covered_byte(w.cmd_sub);
            push_covered_byte(w.body_length[7:0]);
            push_covered_byte(w.body_length[15:8]);
            push_covered_byte(w.sequence_req[7:0]);
            push_covered_byte(w.sequence_req[15:8]);
            if (w.body_length == 16'd0)
                push_crc_bytes();
            else
            begin
                body_left = w.body_length;
                frame_busy = 1'b1;
            end
        end
        else if (frame_busy)
        begin
            push_covered_byte(w.data_byte);
            body_left = body_left - 16'd1;
            if (body_left == 16'd0)
                push_crc_bytes();
        end
        return bytes_pushed - first;
    endfunction

    function automatic void report(string what, int expected_val, int actual_val);
        mismatches++;
        if (mismatches <= SHOWN_MISMATCHES)
            $display("mismatch on %s: expected %0h, got %0h", what, expected_val, actual_val);
    endfunction

    function automatic msg_word_t random_word(logic command);
        msg_word_t w;
        w.command = command;
        w.sender = 8'($urandom);
        w.receiver = 8'($urandom);
        w.cmd_code = 8'($urandom);
        w.cmd_sub = 8'($urandom);
        w.body_length = 16'($urandom);
        w.sequence_req = 16'($urandom);
        w.data_byte = 8'($urandom);
        return w;
    endfunction

    function automatic directed_row_t row(logic command, logic [7:0] sender,
                                          logic [7:0] receiver, logic [7:0] cmd_code,
                                          logic [7:0] cmd_sub, logic [15:0] body_length,
                                          logic [15:0] sequence_req, logic [7:0] data_byte,
                                          int n_bytes);
        directed_row_t r;
        r.word.command = command;
        r.word.sender = sender;
        r.word.receiver = receiver;
        r.word.cmd_code = cmd_code;
        r.word.cmd_sub = cmd_sub;
        r.word.body_length = body_length;
        r.word.sequence_req = sequence_req;
        r.word.data_byte = data_byte;
        r.n_bytes = n_bytes;
        return r;
    endfunction

    always @(posedge clk)
    begin
        frame_out_t e;
        if (rst_n && frame_ch.valid && frame_ch.ready)
        begin
            if (frame_bytes_due.size() == 0)
                report("unexpected frame byte", 0, frame_ch.frame_byte);
            else
            begin
                e = frame_bytes_due.pop_front();
                if (e.value !== frame_ch.frame_byte)
                    report("frame_byte", e.value, frame_ch.frame_byte);
                if (e.last !== frame_ch.frame_last)
                    report("frame_last", e.last, frame_ch.frame_last);
            end
        end
    end

    always @(negedge clk)
    begin
        frame_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (msg_ch.valid && msg_ch.ready) || (frame_ch.valid && frame_ch.ready))
            idle_cycles = 0;
        else
        begin
            idle_cycles = idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // Called and returning at a falling edge.
    task automatic send_word(msg_word_t w, bit no_gaps, output int n_bytes);
        while (!no_gaps && $urandom_range(0, 99) < gap_pct)
        begin
            msg_ch.valid <= 1'b0;
            @(negedge clk);
        end
        msg_ch.valid <= 1'b1;
        msg_ch.command <= w.command;
        msg_ch.sender <= w.sender;
        msg_ch.receiver <= w.receiver;
        msg_ch.cmd_code <= w.cmd_code;
        msg_ch.cmd_sub <= w.cmd_sub;
        msg_ch.body_length <= w.body_length;
        msg_ch.sequence_req <= w.sequence_req;
        msg_ch.data_byte <= w.data_byte;
        do
            @(posedge clk);
        while (!msg_ch.ready);
        n_bytes = predict_frame_bytes(w);
        @(negedge clk);
    endtask

    task automatic drain_frames();
        msg_ch.valid <= 1'b0;
        while (frame_bytes_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_markers(logic [7:0] head, logic [7:0] tail);
        cfg_we <= 1'b1;
        cfg_index <= REG_HEAD;
        cfg_data <= head;
        @(negedge clk);
        cfg_index <= REG_TAIL;
        cfg_data <= tail;
        @(negedge clk);
        cfg_we <= 1'b0;
        head_marker = head;
        tail_marker = tail;
    endtask

    // Mostly complete frames, some cut short or restarted, and some stray body words.
    task automatic run_random_frames(int target);
        msg_word_t w;
        int        words;
        int        pick;
        int        len;
        int        n_body;
        int        n;
        words = 0;
        while (words < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
                n_body = len;
            end
            else if (pick < 88)
            begin
                len = $urandom_range(0, 1) ? $urandom_range(1, 65535) : $urandom_range(2, 8);
                n_body = $urandom_range(0, (len - 1 < 6) ? len - 1 : 6);
            end
            else
            begin
                len = -1;
                n_body = $urandom_range(1, 3);
            end
            if (len >= 0)
            begin
                w = random_word(KIND_START);
                w.body_length = 16'(len);
                send_word(w, 1'b0, n);
                words++;
            end
            for (int i = 0; i < n_body; i++)
            begin
                send_word(random_word(KIND_BODY), 1'b0, n);
                if (n > 0)
                    words++;
            end
        end
    endtask

    initial
    begin
        int n;
        msg_ch.valid = 1'b0;
        msg_ch.command = KIND_START;
        msg_ch.sender = 8'h00;
        msg_ch.receiver = 8'h00;
        msg_ch.cmd_code = 8'h00;
        msg_ch.cmd_sub = 8'h00;
        msg_ch.body_length = 16'h0000;
        msg_ch.sequence_req = 16'h0000;
        msg_ch.data_byte = 8'h00;
        frame_ch.ready = 1'b0;
        head_marker = 8'h00;
        tail_marker = 8'h00;
        frame_crc = CRC_INIT;
        body_left = 16'd0;
        frame_busy = 1'b0;
        bytes_pushed = 0;
        mismatches = 0;
        gap_pct = 0;
        stall_pct = 0;
        idle_cycles = 0;

        directed_rows = '{
            row(KIND_BODY,  8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'hA5, 0),
            row(KIND_START, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'h00, 12),
            row(KIND_START, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'h0000, 16'hFFFF, 8'hFF, 12),
            row(KIND_START, 8'h01, 8'h02, 8'h03, 8'h04, 16'h0001, 16'h1234, 8'h5A, 10),
            row(KIND_BODY,  8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 8'h00, 3),
            row(KIND_BODY,  8'h12, 8'h34, 8'h56, 8'h78, 16'h0003, 16'h0000, 8'hC3, 0),
            row(KIND_START, 8'h10, 8'h20, 8'h30, 8'h40, 16'h0003, 16'h8001, 8'h00, 10),
            row(KIND_BODY,  8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'hFF, 1),
            row(KIND_BODY,  8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'h80, 1),
            row(KIND_BODY,  8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'h01, 3),
            row(KIND_START, 8'hAA, 8'h55, 8'h0F, 8'hF0, 16'h0002, 16'h0100, 8'h00, 10),
            row(KIND_BODY,  8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'h3C, 1),
            row(KIND_START, 8'h55, 8'hAA, 8'hF0, 8'h0F, 16'h0000, 16'h00FF, 8'h00, 12),
            row(KIND_BODY,  8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'h77, 0),
            row(KIND_START, 8'hFE, 8'hEF, 8'h7F, 8'h80, 16'hFFFF, 16'h7FFF, 8'h00, 10),
            row(KIND_BODY,  8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'h11, 1),
            row(KIND_BODY,  8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'h22, 1),
            row(KIND_START, 8'h01, 8'h01, 8'h01, 8'h01, 16'h0100, 16'h0001, 8'h00, 10),
            row(KIND_BODY,  8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'h33, 1),
            row(KIND_START, 8'h02, 8'h03, 8'h04, 8'h05, 16'h0001, 16'hFF00, 8'h00, 10),
            row(KIND_BODY,  8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'h44, 3)
        };

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            send_word(directed_rows[i].word, 1'b1, n);
            if (n != directed_rows[i].n_bytes)
                report("bytes for a table word", directed_rows[i].n_bytes, n);
        end
        drain_frames();

        write_markers(8'hFF, 8'hFF);
        run_random_frames(WORDS_PER_PHASE);
        drain_frames();

        gap_pct = 60;
        write_markers(8'h00, 8'h5A);
        run_random_frames(WORDS_PER_PHASE);
        drain_frames();

        gap_pct = 0;
        stall_pct = 60;
        write_markers(8'($urandom), 8'($urandom));
        run_random_frames(WORDS_PER_PHASE);
        drain_frames();

        gap_pct = 36;
        stall_pct = 36;
        write_markers(8'hA5, 8'h00);
        run_random_frames(WORDS_PER_PHASE);
        drain_frames();

        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
